// ===== sv/mhi_pkg.sv =====
package mhi_pkg;

  // default heap size and item width
  localparam int CAPACITY_DEF = 1024;
  localparam int VALUE_W      = 32;

  // sequencer step addresses
  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_FULLQ = 3'd1;
  localparam step_t STEP_CHECK = 3'd2;
  localparam step_t STEP_CMP   = 3'd3;
  localparam step_t STEP_PLACE = 3'd4;
  localparam step_t STEP_DROP  = 3'd5;

  // branch conditions
  typedef enum logic [2:0] {
    COND_ACCEPT,
    COND_FULL,
    COND_ZERO,
    COND_GT,
    COND_OUTFREE
  } cond_t;

  // one control word: branch on cond to tgt, else hold or step on
  typedef struct packed {
    cond_t cond;
    step_t tgt;
    logic  hold;
    logic  ld_in;
    logic  rd_par;
    logic  mv_par;
    logic  wr_val;
    logic  emit_ok;
    logic  emit_full;
  } ctl_t;

  // control store
  function automatic ctl_t mhi_ucode(input step_t step);
    ctl_t c;
    c = '{cond: COND_OUTFREE, tgt: STEP_IDLE, hold: 1'b0, ld_in: 1'b0, rd_par: 1'b0,
          mv_par: 1'b0, wr_val: 1'b0, emit_ok: 1'b0, emit_full: 1'b0};
    case (step)
      // wait for a request, latch value and the free slot
      STEP_IDLE: begin
        c.cond  = COND_ACCEPT;
        c.tgt   = STEP_FULLQ;
        c.hold  = 1'b1;
        c.ld_in = 1'b1;
      end
      // heap already full: go drop it
      STEP_FULLQ: begin
        c.cond = COND_FULL;
        c.tgt  = STEP_DROP;
      end
      // at the root: place it, else fetch the parent
      STEP_CHECK: begin
        c.cond   = COND_ZERO;
        c.tgt    = STEP_PLACE;
        c.rd_par = 1'b1;
      end
      // strictly greater: move parent down and climb one level
      STEP_CMP: begin
        c.cond   = COND_GT;
        c.tgt    = STEP_CHECK;
        c.mv_par = 1'b1;
      end
      // write value at its slot and report once the output is free
      STEP_PLACE: begin
        c.cond    = COND_OUTFREE;
        c.tgt     = STEP_IDLE;
        c.hold    = 1'b1;
        c.wr_val  = 1'b1;
        c.emit_ok = 1'b1;
      end
      // report a dropped value
      STEP_DROP: begin
        c.cond      = COND_OUTFREE;
        c.tgt       = STEP_IDLE;
        c.hold      = 1'b1;
        c.emit_full = 1'b1;
      end
      default: begin
        c.cond = COND_OUTFREE;
        c.tgt  = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== sv/mhi_ram.sv =====
module mhi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/max_heap_insert.sv =====
// binary max heap insert with sift-up, one request at a time
// steps: request latched in idle, full check, then per level a parent read and a compare with
// write-back, then the place step; a request to a full heap goes from the full check to the drop step
// throughput: next request taken the cycle after the result is registered; in_stall stays high
// from accept until then, and out_stall holds the sequencer in the place or drop step
// reset: rst_n synchronous active low clears count, sequencer and output valid; heap ram not cleared
module max_heap_insert #(
  parameter int CAPACITY = mhi_pkg::CAPACITY_DEF,
  parameter int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mhi_pkg::VALUE_W-1:0] in_new_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [SLOT_W-1:0]                  out_final_slot,
  output logic                               out_heap_full,
  output logic [CNT_W-1:0]                   out_entry_count
);

  import mhi_pkg::*;

  step_t                      pc_r, pc_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic signed [VALUE_W-1:0]  val_r, val_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]          out_slot_r, out_slot_nxt;
  logic                       out_full_r, out_full_nxt;
  logic [CNT_W-1:0]           out_count_r, out_count_nxt;

  ctl_t                       ctl;
  logic                       accept;
  logic                       cond_hit;
  logic                       is_full;
  logic                       out_free;
  logic                       greater;
  logic [SLOT_W-1:0]          up_slot;
  logic                       ram_we;
  logic [VALUE_W-1:0]         ram_wdata;
  logic [VALUE_W-1:0]         ram_rdata;

  // heap storage
  mhi_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(ram_wdata),
    .re   (ctl.rd_par),
    .raddr(up_slot),
    .rdata(ram_rdata)
  );

  // handshake and datapath status
  assign in_stall = (pc_r != STEP_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r >= CNT_W'(CAPACITY));
  assign out_free = !out_valid_r || !out_stall;
  assign greater  = (val_r > $signed(ram_rdata));
  assign up_slot  = (slot_r - 1'b1) >> 1;
  assign ctl      = mhi_ucode(pc_r);

  // branch condition select
  always_comb begin
    case (ctl.cond)
      COND_ACCEPT:  cond_hit = accept;
      COND_FULL:    cond_hit = is_full;
      COND_ZERO:    cond_hit = (slot_r == '0);
      COND_GT:      cond_hit = greater;
      COND_OUTFREE: cond_hit = out_free;
      default:      cond_hit = 1'b0;
    endcase
  end

  // sequencer and datapath next state
  always_comb begin
    pc_nxt        = cond_hit ? ctl.tgt : (ctl.hold ? pc_r : step_t'(pc_r + 1'b1));
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    val_nxt       = val_r;
    ram_we        = 1'b0;
    ram_wdata     = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt  = out_slot_r;
    out_full_nxt  = out_full_r;
    out_count_nxt = out_count_r;

    // latch request and start at the free slot
    if (ctl.ld_in && cond_hit) begin
      val_nxt  = in_new_value;
      slot_nxt = count_r[SLOT_W-1:0];
    end
    // parent moves down into the current slot
    if (ctl.mv_par && cond_hit) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
      slot_nxt  = up_slot;
    end
    // value comes to rest
    if (ctl.wr_val && cond_hit) begin
      ram_we    = 1'b1;
      ram_wdata = val_r;
      count_nxt = count_r + 1'b1;
    end
    if (ctl.emit_ok && cond_hit) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = slot_r;
      out_full_nxt  = 1'b0;
      out_count_nxt = count_r + 1'b1;
    end
    if (ctl.emit_full && cond_hit) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = '0;
      out_full_nxt  = 1'b1;
      out_count_nxt = count_r;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r      <= slot_nxt;
    val_r       <= val_nxt;
    out_slot_r  <= out_slot_nxt;
    out_full_r  <= out_full_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_final_slot  = out_slot_r;
  assign out_heap_full   = out_full_r;
  assign out_entry_count = out_count_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> out_count_r == CNT_W'(CAPACITY))
    else $error("drop reported on a heap that is not full");

  a_slot_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_full_r |-> CNT_W'(out_slot_r) < out_count_r)
    else $error("final slot outside the heap");

  a_cmp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == STEP_CMP |-> slot_r != '0)
    else $error("parent compare at the root");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != count_nxt |-> pc_r == STEP_PLACE && out_free)
    else $error("count changed outside of a placed value");

endmodule

// ===== dv/tb_max_heap_insert.sv =====
`timescale 1ns / 100ps

module tb_max_heap_insert;
  import mhi_pkg::*;

  localparam int CAP    = mhi_pkg::CAPACITY_DEF;
  localparam int SLOT_W = $clog2(CAP);
  localparam int CNT_W  = $clog2(CAP + 1);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic [CNT_W-1:0]  count;
  } insert_res_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [VALUE_W-1:0]  in_new_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [SLOT_W-1:0]          out_final_slot;
  logic                       out_heap_full;
  logic [CNT_W-1:0]           out_entry_count;

  // shadow heap and its fill level
  logic signed [VALUE_W-1:0]  shadow_heap [CAP];
  int                         heap_count;
  insert_res_t                awaited_inserts [$];
  logic signed [VALUE_W-1:0]  climb_value;
  int                         err_cnt;
  bit                         idle_on;
  int                         hold_cycles;

  max_heap_insert i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_final_slot  (out_final_slot),
    .out_heap_full   (out_heap_full),
    .out_entry_count (out_entry_count)
  );

  // clock, 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // insert into the shadow heap, sift up, and return the expected result
  function automatic insert_res_t sift_up_insert(input logic signed [VALUE_W-1:0] v);
    insert_res_t               r;
    int                        slot;
    int                        up;
    logic signed [VALUE_W-1:0] tmp;
    if (heap_count >= CAP) begin
      r.slot  = '0;
      r.full  = 1'b1;
      r.count = CNT_W'(heap_count);
      return r;
    end
    slot = heap_count;
    shadow_heap[slot] = v;
    heap_count++;
    while (slot > 0) begin
      up = (slot - 1) / 2;
      if (!(shadow_heap[slot] > shadow_heap[up])) break;
      tmp = shadow_heap[up];
      shadow_heap[up] = shadow_heap[slot];
      shadow_heap[slot] = tmp;
      slot = up;
    end
    r.slot  = SLOT_W'(slot);
    r.full  = 1'b0;
    r.count = CNT_W'(heap_count);
    return r;
  endfunction

  // mix of wide random, clustered, rising and extreme values
  function automatic logic signed [VALUE_W-1:0] rand_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 15)) - 8;
      3: begin
        climb_value = climb_value + $urandom_range(0, 3);
        v = climb_value;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = -$signed($urandom_range(0, 1000));
    endcase
    return v;
  endfunction

  // offer one request, wait for it to be taken, then predict its result
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_new_value = v;
    do @(posedge clk); while (in_stall);
    awaited_inserts.push_back(sift_up_insert(v));
    @(negedge clk);
  endtask

  // receiver: random stall bursts, plus a long hold when requested
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    insert_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_inserts.size() == 0) begin
        $error("result with no pending insert: slot %0d full %0d count %0d",
               out_final_slot, out_heap_full, out_entry_count);
        err_cnt++;
      end else begin
        e = awaited_inserts.pop_front();
        if (out_final_slot !== e.slot) begin
          $error("final_slot mismatch: expected %0d, actual %0d", e.slot, out_final_slot);
          err_cnt++;
        end
        if (out_heap_full !== e.full) begin
          $error("heap_full mismatch: expected %0d, actual %0d", e.full, out_heap_full);
          err_cnt++;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count mismatch: expected %0d, actual %0d", e.count, out_entry_count);
          err_cnt++;
        end
      end
    end
  end

  // empty heap first, then the extremes of the value range
  task automatic test_extremes();
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(-1);
    send_value(0);
    send_value(1);
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);
    send_value(32'sh7FFF_FFFE);
    send_value(32'sh8000_0001);
  endtask

  // equal to parent: climb must stop, greater values still rise
  task automatic test_equal_parent();
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh7FFF_FFFF);
    send_value(5);
    send_value(5);
    send_value(5);
    send_value(6);
    send_value(-1);
    send_value(-1);
    send_value(0);
    send_value(32'sh8000_0000);
  endtask

  task automatic test_random_inserts(input int n);
    repeat (n) send_value(rand_value());
  endtask

  // long output hold while requests keep coming, fills up and stalls input
  task automatic test_backpressure();
    hold_cycles = 150;
    repeat (12) send_value(rand_value());
  endtask

  task automatic test_fill_to_capacity();
    while (heap_count < CAP) send_value(rand_value());
  endtask

  // heap full: every request is dropped, no idling in this last part
  task automatic test_full_heap();
    idle_on = 1'b0;
    repeat (320) send_value(rand_value());
  endtask

  // stimulus sequence
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_new_value = '0;
    heap_count   = 0;
    err_cnt      = 0;
    climb_value  = -50;
    idle_on      = 1'b1;
    hold_cycles  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_equal_parent();
    test_random_inserts(300);
    test_backpressure();
    test_random_inserts(300);
    test_fill_to_capacity();
    test_full_heap();

    in_valid = 1'b0;
    while (awaited_inserts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mhi_pkg.sv
sv/mhi_ram.sv
sv/max_heap_insert.sv
dv/tb_max_heap_insert.sv
